// ----- hw/rtl/dssd_pkg.sv -----
// ----------------------------------------------------------------------------
// dssd_pkg
// Shared types, constants and the segment table for the display driver.
// ----------------------------------------------------------------------------
package dssd_pkg;

  localparam int MAX_DIGITS = 8;

  localparam int CNT_W  = 4;
  localparam int NUM_W  = 28;
  localparam int Q_W    = 25;
  localparam int PROD_W = 60;
  localparam int RECIP_SHIFT = 35;
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

  localparam logic [1:0] FUNC_INIT    = 2'd0;
  localparam logic [1:0] FUNC_SET_NUM = 2'd1;
  localparam logic [1:0] FUNC_REFRESH = 2'd2;

  localparam logic [3:0] REG_DECODE     = 4'h9;
  localparam logic [3:0] REG_INTENSITY  = 4'hA;
  localparam logic [3:0] REG_SCAN_LIMIT = 4'hB;
  localparam logic [3:0] REG_POWER      = 4'hC;

  localparam logic [7:0] DATA_DECODE_OFF = 8'h00;
  localparam logic [7:0] DATA_INTENSITY  = 8'h08;
  localparam logic [7:0] DATA_POWER_ON   = 8'h01;

  localparam logic [7:0] PAT_MINUS = 8'h01;
  localparam logic [7:0] PAT_BLANK = 8'h00;
  localparam logic [7:0] PAT_DOT   = 8'h80;

  typedef enum logic [2:0] {
    FR_DECODE = 3'd0,
    FR_SCAN   = 3'd1,
    FR_INTENS = 3'd2,
    FR_POWER  = 3'd3,
    FR_BLANK  = 3'd4,
    FR_DIGIT  = 3'd5
  } frame_t;

  typedef struct packed {
    logic   load;
    logic   div;
    logic   digit;
    logic   minus;
    logic   blank;
    logic   idx_inc;
    logic   idx_dec;
    logic   idx_load_cnt;
    logic   copy;
    logic   emit;
    frame_t frame;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic neg;
    logic q_zero;
    logic idx_lt_count;
    logic idx_is_one;
    logic idx_last;
    logic differ;
  } sts_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h7E;
      4'd1:    p = 8'h30;
      4'd2:    p = 8'h6D;
      4'd3:    p = 8'h79;
      4'd4:    p = 8'h33;
      4'd5:    p = 8'h5B;
      4'd6:    p = 8'h5F;
      4'd7:    p = 8'h70;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h7B;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/dssd_ctrl.sv -----
// ----------------------------------------------------------------------------
// dssd_ctrl
// Command sequencer: init frames, per-digit conversion, refresh frames.
// ----------------------------------------------------------------------------
module dssd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_func,
  output logic                in_stall,
  input  dssd_pkg::sts_t      sts,
  output dssd_pkg::cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_IDLE       = 12'b0000_0000_0001,
    S_INIT_DEC   = 12'b0000_0000_0010,
    S_INIT_SCAN  = 12'b0000_0000_0100,
    S_INIT_INT   = 12'b0000_0000_1000,
    S_INIT_PWR   = 12'b0000_0001_0000,
    S_INIT_BLANK = 12'b0000_0010_0000,
    S_NUM_DIV    = 12'b0000_0100_0000,
    S_NUM_DIG    = 12'b0000_1000_0000,
    S_NUM_MINUS  = 12'b0001_0000_0000,
    S_NUM_FILL   = 12'b0010_0000_0000,
    S_REF_CHK    = 12'b0100_0000_0000,
    S_REF_EMIT   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.frame = dssd_pkg::FR_DECODE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_func)
            dssd_pkg::FUNC_INIT:    state_nxt = S_INIT_DEC;
            dssd_pkg::FUNC_SET_NUM: state_nxt = S_NUM_DIV;
            dssd_pkg::FUNC_REFRESH: state_nxt = S_REF_CHK;
            default:                state_nxt = S_IDLE;
          endcase
        end
      end
      S_INIT_DEC: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.frame = dssd_pkg::FR_DECODE;
          state_nxt = S_INIT_SCAN;
        end
      end
      S_INIT_SCAN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.frame = dssd_pkg::FR_SCAN;
          state_nxt = S_INIT_INT;
        end
      end
      S_INIT_INT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.frame = dssd_pkg::FR_INTENS;
          state_nxt = S_INIT_PWR;
        end
      end
      S_INIT_PWR: begin
        if (sts.out_free) begin
          cmd.emit         = 1'b1;
          cmd.frame        = dssd_pkg::FR_POWER;
          cmd.idx_load_cnt = 1'b1;
          state_nxt        = S_INIT_BLANK;
        end
      end
      S_INIT_BLANK: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.frame   = dssd_pkg::FR_BLANK;
          cmd.idx_dec = 1'b1;
          if (sts.idx_is_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_NUM_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_NUM_DIG;
      end
      S_NUM_DIG: begin
        cmd.digit   = 1'b1;
        cmd.idx_inc = 1'b1;
        if (!sts.q_zero) begin
          state_nxt = S_NUM_DIV;
        end else if (sts.neg) begin
          state_nxt = S_NUM_MINUS;
        end else begin
          state_nxt = S_NUM_FILL;
        end
      end
      S_NUM_MINUS: begin
        cmd.minus   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_NUM_FILL;
      end
      S_NUM_FILL: begin
        if (sts.idx_lt_count) begin
          cmd.blank   = 1'b1;
          cmd.idx_inc = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_REF_CHK: begin
        state_nxt = sts.differ ? S_REF_EMIT : S_IDLE;
      end
      S_REF_EMIT: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.frame   = dssd_pkg::FR_DIGIT;
          cmd.idx_inc = 1'b1;
          if (sts.idx_last) begin
            cmd.copy  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/dssd_datapath.sv -----
// ----------------------------------------------------------------------------
// dssd_datapath
// Digit stores, divide-by-ten step, digit-count register and output frame.
// ----------------------------------------------------------------------------
module dssd_datapath #(
  parameter int MAX_DIGITS = dssd_pkg::MAX_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dssd_pkg::cmd_t              cmd,
  output dssd_pkg::sts_t              sts,
  input  logic signed [27:0]          in_number,
  input  logic [3:0]                  in_dot_place,
  input  logic                        cfg_we,
  input  logic [3:0]                  cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_reg_addr,
  output logic [7:0]                  out_reg_data,
  output logic                        out_last
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW    = dssd_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DIGITS);

  logic [CW-1:0]                 cfg_r;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic [dssd_pkg::NUM_W-1:0]    mag_r;
  logic [dssd_pkg::Q_W-1:0]      q_r;
  logic [3:0]                    dot_r;
  logic                          neg_r;
  logic [7:0]                    digit_r [MAX_DIGITS];
  logic [7:0]                    sent_r  [MAX_DIGITS];
  logic [dssd_pkg::PROD_W-1:0]   prod;
  logic [dssd_pkg::NUM_W-1:0]    q10;
  logic [dssd_pkg::NUM_W-1:0]    rem_full;
  logic [7:0]                    num_pat;
  logic [7:0]                    wr_pat;
  logic                          wr_en;
  logic [IDX_W-1:0]              idx_a;
  logic                          differ;
  logic                          out_valid_r;
  logic [3:0]                    addr_r, addr_nxt;
  logic [7:0]                    data_r, data_nxt;
  logic                          last_r, last_nxt;

  assign idx_a = idx_r[IDX_W-1:0];

  // digit count register and clamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= MAX_CNT;
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  always_comb begin
    if (cfg_r == '0) begin
      count = CW'(1);
    end else if (cfg_r > MAX_CNT) begin
      count = MAX_CNT;
    end else begin
      count = cfg_r;
    end
  end

  // divide by ten: reciprocal multiply, registered, then remainder
  assign prod     = dssd_pkg::PROD_W'(mag_r) * dssd_pkg::PROD_W'(dssd_pkg::RECIP_10);
  assign q10      = (dssd_pkg::NUM_W'(q_r) << 3) + (dssd_pkg::NUM_W'(q_r) << 1);
  assign rem_full = mag_r - q10;
  assign num_pat  = dssd_pkg::seg_pattern(rem_full[3:0]) |
                    ((idx_r == dot_r) ? dssd_pkg::PAT_DOT : 8'h00);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_number[27];
      dot_r <= in_dot_place;
      mag_r <= in_number[27] ? (dssd_pkg::NUM_W'(0) - in_number) : in_number;
    end else if (cmd.digit) begin
      mag_r <= dssd_pkg::NUM_W'(q_r);
    end
    if (cmd.div) begin
      q_r <= prod[dssd_pkg::RECIP_SHIFT +: dssd_pkg::Q_W];
    end
  end

  // index counter
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.idx_load_cnt) begin
      idx_nxt = count;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - CW'(1);
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // digit and sent stores
  always_comb begin
    if (cmd.digit) begin
      wr_pat = num_pat;
    end else if (cmd.minus) begin
      wr_pat = dssd_pkg::PAT_MINUS;
    end else begin
      wr_pat = dssd_pkg::PAT_BLANK;
    end
  end

  assign wr_en = (cmd.digit || cmd.minus || cmd.blank) && (idx_r < MAX_CNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
        digit_r[k] <= '0;
        sent_r[k]  <= '0;
      end
    end else begin
      if (wr_en) begin
        digit_r[idx_a] <= wr_pat;
      end
      if (cmd.copy) begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
          sent_r[k] <= digit_r[k];
        end
      end
    end
  end

  always_comb begin
    differ = 1'b0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      differ = differ | (digit_r[k] != sent_r[k]);
    end
  end

  // output frame register
  always_comb begin
    addr_nxt = dssd_pkg::REG_DECODE;
    data_nxt = dssd_pkg::DATA_DECODE_OFF;
    last_nxt = 1'b0;
    case (cmd.frame)
      dssd_pkg::FR_DECODE: begin
        addr_nxt = dssd_pkg::REG_DECODE;
        data_nxt = dssd_pkg::DATA_DECODE_OFF;
      end
      dssd_pkg::FR_SCAN: begin
        addr_nxt = dssd_pkg::REG_SCAN_LIMIT;
        data_nxt = 8'(count - CW'(1));
      end
      dssd_pkg::FR_INTENS: begin
        addr_nxt = dssd_pkg::REG_INTENSITY;
        data_nxt = dssd_pkg::DATA_INTENSITY;
      end
      dssd_pkg::FR_POWER: begin
        addr_nxt = dssd_pkg::REG_POWER;
        data_nxt = dssd_pkg::DATA_POWER_ON;
      end
      dssd_pkg::FR_BLANK: begin
        addr_nxt = idx_r;
        data_nxt = dssd_pkg::PAT_BLANK;
        last_nxt = (idx_r == CW'(1));
      end
      dssd_pkg::FR_DIGIT: begin
        addr_nxt = idx_r + CW'(1);
        data_nxt = digit_r[idx_a];
        last_nxt = (idx_r + CW'(1) == count);
      end
      default: begin
        addr_nxt = dssd_pkg::REG_DECODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_reg_addr = addr_r;
  assign out_reg_data = data_r;
  assign out_last     = last_r;

  assign sts.out_free     = !out_valid_r || !out_stall;
  assign sts.neg          = neg_r;
  assign sts.q_zero       = (q_r == '0);
  assign sts.idx_lt_count = (idx_r < count);
  assign sts.idx_is_one   = (idx_r == CW'(1));
  assign sts.idx_last     = (idx_r + CW'(1) == count);
  assign sts.differ       = differ;

endmodule

// ----- hw/rtl/decimal_seven_segment_display_driver.sv -----
// ----------------------------------------------------------------------------
// decimal_seven_segment_display_driver
// Turns display commands into register write words for a seven-segment
// display controller.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one command word per accept. in_stall
// is high while a command is in progress; one command is worked at a time.
//   init:       4 setup words then count blank words, one word per cycle
//               when the output is not stalled.
//   set number: a divide-by-ten step per decimal digit (reciprocal
//               multiply, then remainder), then a minus sign if negative
//               and blank fill up to the digit count. No output.
//   refresh:    a compare step, then count digit words if anything changed.
// Output channel (out_valid/out_stall): a single output register; a word
// waits there while out_stall is high and the sequencer holds until it
// frees. out_last marks the final word of a command.
// cfg_we/cfg_data write the digit count (0 acts as 1, large values clamp).
// Reset (rst_n, synchronous): digit count 8, both digit stores zero, output
// empty, ready for a command on the next cycle.
// ----------------------------------------------------------------------------
module decimal_seven_segment_display_driver #(
  parameter int MAX_DIGITS = dssd_pkg::MAX_DIGITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [27:0] in_number,
  input  logic [3:0]         in_dot_place,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_reg_addr,
  output logic [7:0]         out_reg_data,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data
);

  dssd_pkg::cmd_t cmd;
  dssd_pkg::sts_t sts;

  dssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dssd_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_number    (in_number),
    .in_dot_place (in_dot_place),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_reg_addr (out_reg_addr),
    .out_reg_data (out_reg_data),
    .out_last     (out_last)
  );

endmodule

// ----- verif/decimal_seven_segment_display_driver_test.sv -----
// ----------------------------------------------------------------------------
// decimal_seven_segment_display_driver_test
// Self-checking bench: drives init, set-number, refresh and unused commands,
// predicts every register write word from its own model of the digit stores
// and the digit count, and checks the words in order under random idling,
// output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module decimal_seven_segment_display_driver_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [7:0] DIGIT_SEGS [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };

  typedef struct {
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = dssd_pkg::FUNC_INIT;
  logic signed [27:0] in_number = '0;
  logic [3:0]         in_dot_place = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_reg_addr;
  logic [7:0]         out_reg_data;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_data = '0;

  word_t pending_frames[$];
  logic [dssd_pkg::MAX_DIGITS-1:0][7:0] digits_wanted;
  logic [dssd_pkg::MAX_DIGITS-1:0][7:0] digits_shown;
  logic [3:0] digit_count;

  int error_count = 0;
  int cycle_count = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold_cycles = 0;
  int rx_burst_left = 0;

  decimal_seven_segment_display_driver DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_number    (in_number),
    .in_dot_place (in_dot_place),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_reg_addr (out_reg_addr),
    .out_reg_data (out_reg_data),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** decimal_seven_segment_display_driver: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned active_digits();
    int unsigned c;
    c = digit_count;
    if (c < 1) c = 1;
    if (c > dssd_pkg::MAX_DIGITS) c = dssd_pkg::MAX_DIGITS;
    return c;
  endfunction

  function automatic void push_frame(input logic [3:0] addr, input logic [7:0] data,
                                     input logic last);
    word_t f;
    f.addr = addr;
    f.data = data;
    f.last = last;
    pending_frames.push_back(f);
  endfunction

  function automatic void predict_frames(input logic [1:0] func, input logic [27:0] number,
                                         input logic [3:0] dot);
    int unsigned cnt;
    int unsigned mag;
    int unsigned i;
    logic [7:0] pat;
    cnt = active_digits();
    case (func)
      dssd_pkg::FUNC_INIT: begin
        push_frame(dssd_pkg::REG_DECODE, dssd_pkg::DATA_DECODE_OFF, 1'b0);
        push_frame(dssd_pkg::REG_SCAN_LIMIT, 8'(cnt - 1), 1'b0);
        push_frame(dssd_pkg::REG_INTENSITY, dssd_pkg::DATA_INTENSITY, 1'b0);
        push_frame(dssd_pkg::REG_POWER, dssd_pkg::DATA_POWER_ON, 1'b0);
        for (int d = cnt; d >= 1; d--) begin
          push_frame(4'(d), dssd_pkg::PAT_BLANK, d == 1);
        end
      end
      dssd_pkg::FUNC_SET_NUM: begin
        mag = number[27] ? 32'h1000_0000 - {4'h0, number} : {4'h0, number};
        i = 0;
        do begin
          pat = DIGIT_SEGS[mag % 10];
          if (i == dot) pat = pat | dssd_pkg::PAT_DOT;
          if (i < dssd_pkg::MAX_DIGITS) digits_wanted[i] = pat;
          i++;
          mag = mag / 10;
        end while (mag != 0);
        if (number[27]) begin
          if (i < dssd_pkg::MAX_DIGITS) digits_wanted[i] = dssd_pkg::PAT_MINUS;
          i++;
        end
        while (i < cnt) begin
          digits_wanted[i] = dssd_pkg::PAT_BLANK;
          i++;
        end
      end
      dssd_pkg::FUNC_REFRESH: begin
        if (digits_wanted != digits_shown) begin
          for (int d = 0; d < cnt; d++) begin
            push_frame(4'(d + 1), digits_wanted[d], d == cnt - 1);
          end
          digits_shown = digits_wanted;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected word addr %0h data %0h last %0b",
                                  out_reg_addr, out_reg_data, out_last));
      end else begin
        want = pending_frames.pop_front();
        if (out_reg_addr !== want.addr)
          report_mismatch($sformatf("reg_addr got %0h expected %0h", out_reg_addr, want.addr));
        if (out_reg_data !== want.data)
          report_mismatch($sformatf("reg_data got %0h expected %0h (addr %0h)",
                                    out_reg_data, want.data, want.addr));
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %0b expected %0b (addr %0h)",
                                    out_last, want.last, want.addr));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall <= 1'b1;
        rx_hold_cycles--;
      end else if (rx_burst_left > 0) begin
        out_stall <= 1'b1;
        rx_burst_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        rx_burst_left = $urandom_range(0, 4);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_cmd(input logic [1:0] func, input logic [27:0] number,
                          input logic [3:0] dot);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_number    <= number;
    in_dot_place <= dot;
    do @(posedge clk); while (in_stall);
    predict_frames(func, number, dot);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_digit_count(input logic [3:0] value);
    drain_outputs();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    digit_count = value;
  endtask

  function automatic logic [27:0] rand_number();
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 99);
      1: v = $urandom_range(0, 99999999);
      2: v = -int'($urandom_range(1, 9999999));
      3: v = -int'($urandom_range(1, 99));
      4: v = $urandom();
      default: v = $urandom_range(0, 10 ** $urandom_range(1, 8) - 1);
    endcase
    return v[27:0];
  endfunction

  function automatic logic [3:0] rand_dot();
    return ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
  endfunction

  task automatic test_after_reset();
    send_cmd(dssd_pkg::FUNC_INIT, '0, 4'd8);
    send_cmd(dssd_pkg::FUNC_REFRESH, '0, 4'd8);
  endtask

  task automatic test_number_edges();
    send_cmd(dssd_pkg::FUNC_SET_NUM, 28'd0, 4'd8);
    send_cmd(dssd_pkg::FUNC_REFRESH, '0, 4'd0);
    send_cmd(dssd_pkg::FUNC_SET_NUM, 28'd99999999, 4'd0);
    send_cmd(dssd_pkg::FUNC_REFRESH, '0, 4'd0);
    send_cmd(dssd_pkg::FUNC_SET_NUM, 28'(-9999999), 4'd7);
    send_cmd(dssd_pkg::FUNC_REFRESH, '0, 4'd0);
    send_cmd(dssd_pkg::FUNC_SET_NUM, 28'h7FF_FFFF, 4'd15);
    send_cmd(dssd_pkg::FUNC_SET_NUM, 28'h800_0000, 4'd3);
    send_cmd(dssd_pkg::FUNC_REFRESH, '0, 4'd0);
    send_cmd(dssd_pkg::FUNC_REFRESH, 28'hFFF_FFFF, 4'd15);
    send_cmd(FUNC_UNUSED, 28'hFFF_FFFF, 4'd15);
  endtask

  task automatic test_digit_count_extremes();
    write_digit_count(4'd15);
    send_cmd(dssd_pkg::FUNC_INIT, '0, 4'd0);
    send_cmd(dssd_pkg::FUNC_SET_NUM, 28'(-5), 4'd0);
    send_cmd(dssd_pkg::FUNC_REFRESH, '0, 4'd0);
    write_digit_count(4'd0);
    send_cmd(dssd_pkg::FUNC_INIT, '0, 4'd0);
    send_cmd(dssd_pkg::FUNC_SET_NUM, 28'(-1), 4'd1);
    send_cmd(dssd_pkg::FUNC_REFRESH, '0, 4'd0);
  endtask

  task automatic test_output_holdoff();
    write_digit_count(4'd8);
    rx_hold_cycles = 400;
    send_cmd(dssd_pkg::FUNC_INIT, '0, 4'd8);
    send_cmd(dssd_pkg::FUNC_SET_NUM, 28'd12345678, 4'd2);
    send_cmd(dssd_pkg::FUNC_REFRESH, '0, 4'd8);
    send_cmd(dssd_pkg::FUNC_INIT, '0, 4'd8);
    send_cmd(dssd_pkg::FUNC_SET_NUM, 28'(-42), 4'd8);
    send_cmd(dssd_pkg::FUNC_REFRESH, '0, 4'd8);
  endtask

  task automatic test_random_traffic();
    int sent;
    int sel;
    for (int p = 0; p < 5; p++) begin
      if (p == 4) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      write_digit_count(p == 0 ? 4'd1 : p == 1 ? 4'd8 : 4'($urandom_range(0, 15)));
      sent = 0;
      while (sent < 50) begin
        sel = $urandom_range(0, 19);
        if (sel < 13) begin
          send_cmd(dssd_pkg::FUNC_SET_NUM, rand_number(), rand_dot());
          send_cmd(dssd_pkg::FUNC_REFRESH, 28'($urandom()), 4'($urandom()));
          sent += 2;
        end else if (sel < 15) begin
          send_cmd(dssd_pkg::FUNC_REFRESH, 28'($urandom()), 4'($urandom()));
          sent++;
        end else if (sel < 17) begin
          send_cmd(dssd_pkg::FUNC_INIT, 28'($urandom()), 4'($urandom()));
          sent++;
        end else if (sel < 19) begin
          send_cmd(dssd_pkg::FUNC_SET_NUM, rand_number(), rand_dot());
          sent++;
        end else begin
          send_cmd(FUNC_UNUSED, 28'($urandom()), 4'($urandom()));
        end
      end
    end
  endtask

  initial begin
    digits_wanted = '0;
    digits_shown  = '0;
    digit_count   = 4'd8;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_number_edges();
    test_digit_count_extremes();
    test_output_holdoff();
    test_random_traffic();
    drain_outputs();
    if (error_count == 0) begin
      $display("** decimal_seven_segment_display_driver: PASSED **");
    end else begin
      $display("** decimal_seven_segment_display_driver: FAILED **");
    end
    $finish;
  end

endmodule
